[sv/catmull_rom_spline_eval_unit_defines.svh]
// Assertion macros for the spline evaluator RTL.
// Depends on nothing; included by catmull_rom_spline_eval_unit, the file that carries assertions.
`ifndef CATMULL_ROM_SPLINE_EVAL_UNIT_DEFINES_SVH
`define CATMULL_ROM_SPLINE_EVAL_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define CRS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("spline eval check failed");

// Next-cycle implication, checked out of reset
`define CRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("spline eval check failed");

`endif

[sv/crs_pkg.sv]
// Shared constants for the Catmull-Rom spline evaluator.
// No dependencies; used by crs_coord and the top level.
package crs_pkg;

	// Width of the point count register
	localparam int CNT_W = 11;
	// Width of the point index field on the input stream
	localparam int IDX_IN_W = 10;
	// Segment number width: param_t up to 2.0 times the count
	localparam int P_W = CNT_W + 1;
	// Headroom of the Horner accumulator above the coordinate width
	localparam int GUARD_BITS = 5;

endpackage

[sv/crs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module crs_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[sv/crs_coord.sv]
// One coordinate lane: basis weights, three Horner steps, halving, saturation.
// Depends on crs_pkg. Stages s3 through s9; s9 is the output register.
module crs_coord #(
	parameter int COORD_BITS = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         adv,
	input  logic signed [COORD_BITS-1:0] p0,
	input  logic signed [COORD_BITS-1:0] p1,
	input  logic signed [COORD_BITS-1:0] p2,
	input  logic signed [COORD_BITS-1:0] p3,
	input  logic        [FRAC_BITS-1:0]  lt,
	output logic signed [COORD_BITS-1:0] value,
	output logic                         sat
);

	localparam int HW = COORD_BITS + crs_pkg::GUARD_BITS;
	localparam int PW = HW + FRAC_BITS + 1;
	localparam logic signed [HW-1:0] CMAX =
		{{(HW - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
	localparam logic signed [HW-1:0] CMIN = ~CMAX;

	logic signed [HW-1:0] e0, e1, e2, e3;
	logic signed [HW-1:0] a_s3, b_s3, c_s3, d_s3;
	logic signed [PW-1:0] pr_s4, pr_s6, pr_s8;
	logic signed [HW-1:0] b_s4, c_s4, d_s4;
	logic signed [HW-1:0] h_s5, c_s5, d_s5;
	logic signed [HW-1:0] c_s6, d_s6;
	logic signed [HW-1:0] h_s7, d_s7;
	logic signed [HW-1:0] d_s8;
	logic [FRAC_BITS-1:0] l_s3, l_s4, l_s5, l_s6, l_s7;
	logic signed [PW-1:0] sh_s8;
	logic signed [HW-1:0] hd, half;

	assign e0 = HW'(p0);
	assign e1 = HW'(p1);
	assign e2 = HW'(p2);
	assign e3 = HW'(p3);

	// s3: basis coefficients
	always_ff @(posedge clk) begin
		if (adv) begin
			a_s3 <= e3 - e0 + (e1 <<< 1) + e1 - (e2 <<< 1) - e2;
			b_s3 <= (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
			c_s3 <= e2 - e0;
			d_s3 <= e1 <<< 1;
			l_s3 <= lt;
		end
	end

	// s4: A * lt
	always_ff @(posedge clk) begin
		if (adv) begin
			pr_s4 <= a_s3 * $signed({1'b0, l_s3});
			b_s4  <= b_s3;
			c_s4  <= c_s3;
			d_s4  <= d_s3;
			l_s4  <= l_s3;
		end
	end

	// s5: floor shift plus B
	always_ff @(posedge clk) begin
		if (adv) begin
			h_s5 <= HW'(pr_s4 >>> FRAC_BITS) + b_s4;
			c_s5 <= c_s4;
			d_s5 <= d_s4;
			l_s5 <= l_s4;
		end
	end

	// s6: h * lt
	always_ff @(posedge clk) begin
		if (adv) begin
			pr_s6 <= h_s5 * $signed({1'b0, l_s5});
			c_s6  <= c_s5;
			d_s6  <= d_s5;
			l_s6  <= l_s5;
		end
	end

	// s7: floor shift plus C
	always_ff @(posedge clk) begin
		if (adv) begin
			h_s7 <= HW'(pr_s6 >>> FRAC_BITS) + c_s6;
			d_s7 <= d_s6;
			l_s7 <= l_s6;
		end
	end

	// s8: h * lt
	always_ff @(posedge clk) begin
		if (adv) begin
			pr_s8 <= h_s7 * $signed({1'b0, l_s7});
			d_s8  <= d_s7;
		end
	end

	// s9: plus D, halve toward minus infinity, saturate
	assign sh_s8 = pr_s8 >>> FRAC_BITS;
	assign hd    = HW'(sh_s8) + d_s8;
	assign half  = hd >>> 1;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (half > CMAX) begin
				value <= CMAX[COORD_BITS-1:0];
				sat   <= 1'b1;
			end else if (half < CMIN) begin
				value <= CMIN[COORD_BITS-1:0];
				sat   <= 1'b1;
			end else begin
				value <= half[COORD_BITS-1:0];
				sat   <= 1'b0;
			end
		end
	end

endmodule

[sv/catmull_rom_spline_eval_unit.sv]
// Uniform Catmull-Rom spline evaluator over a table of 3D control points.
// Depends on crs_pkg, crs_ram, crs_coord and the assertion macro header.
//
// One item enters per clock while m_tready is high. A write item (tuser 0)
// stores a point and gives no result; an evaluate item (tuser 1) gives one
// result at the output stage. The datapath is a nine-stage pipeline (input,
// table read, basis, three multiply/add Horner steps, output) that advances
// as a whole: when the output holds an unaccepted result, the pipeline freezes
// and s_tready drops. The point table is four copies of one RAM so the four
// neighbor points are read in the same cycle; a write is seen by every evaluate
// item accepted after it. The user writes point_count only idle; not enforced.
module catmull_rom_spline_eval_unit #(
	parameter int MAX_POINTS = 1024,
	parameter int COORD_BITS = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic                        cfg_we,
	input  logic [crs_pkg::CNT_W-1:0]   cfg_data,  // point_count
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// point_index, in_x, in_y, in_z, param_t, zero fill
	input  logic [((crs_pkg::IDX_IN_W + 3*COORD_BITS + FRAC_BITS + 1 + 7)/8)*8-1:0] s_tdata,
	input  logic                        s_tuser,   // cmd
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [((3*COORD_BITS + 7)/8)*8-1:0] m_tdata,  // out_x, out_y, out_z, zero fill
	output logic                        m_tuser    // saturated
);

	`include "catmull_rom_spline_eval_unit_defines.svh"

	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = crs_pkg::CNT_W;
	localparam int P_W   = crs_pkg::P_W;
	localparam int TW    = FRAC_BITS + 1;
	localparam int SW    = TW + CNT_W;
	localparam int PTW   = 3 * COORD_BITS;
	localparam int OFF_X = crs_pkg::IDX_IN_W;
	localparam int OFF_T = OFF_X + PTW;
	localparam logic CMD_WRITE = 1'b0;

	logic [CNT_W-1:0] cnt_q;
	logic adv;
	logic [crs_pkg::IDX_IN_W-1:0] pidx;
	logic [CNT_W-1:0] widx;
	logic [SW-1:0] s_mul;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic cmd_s1;
	logic [IDX_W-1:0] widx_s1;
	logic [PTW-1:0] pt_s1;
	logic [SW-1:0] s_s1;
	logic [FRAC_BITS-1:0] l_s2;

	logic [P_W-1:0] seg;
	logic signed [P_W:0] nb [4];
	logic [IDX_W-1:0] raddr [4];
	logic [PTW-1:0] rdata [4];
	logic [COORD_BITS-1:0] ox, oy, oz;
	logic sx, sy, sz;

	// Point count, held in its effective range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CNT_W'(1);
		end else if (cfg_we) begin
			if (cfg_data == '0) begin
				cnt_q <= CNT_W'(1);
			end else if (32'(cfg_data) > MAX_POINTS) begin
				cnt_q <= CNT_W'(MAX_POINTS);
			end else begin
				cnt_q <= cfg_data;
			end
		end
	end

	// Whole pipeline moves unless a result waits at the output
	assign adv      = !v_s9 || m_tready;
	assign s_tready = adv;

	// s1: clamp write index, scale param_t by the count
	assign pidx  = s_tdata[crs_pkg::IDX_IN_W-1:0];
	assign widx  = ({1'b0, pidx} >= cnt_q) ? cnt_q - CNT_W'(1) : CNT_W'(pidx);
	assign s_mul = SW'(s_tdata[OFF_T +: TW]) * SW'(cnt_q);

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1  <= s_tuser;
			widx_s1 <= IDX_W'(widx);
			pt_s1   <= s_tdata[OFF_X +: PTW];
			s_s1    <= s_mul;
		end
	end

	// Valid bits, one per stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1 && (cmd_s1 != CMD_WRITE);
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// Neighbor indices p-1 .. p+2, clamped to the table in use
	assign seg = s_s1[SW-1 -: P_W];

	for (genvar k = 0; k < 4; k++) begin : g_tap
		assign nb[k] = $signed({1'b0, seg}) + (P_W+1)'(k - 1);
		always_comb begin
			if (nb[k] < 0) begin
				raddr[k] = '0;
			end else if (nb[k] >= $signed({2'b00, cnt_q})) begin
				raddr[k] = IDX_W'(cnt_q - CNT_W'(1));
			end else begin
				raddr[k] = IDX_W'(nb[k]);
			end
		end

		crs_ram #(.WIDTH(PTW), .DEPTH(MAX_POINTS)) u_ram (
			.clk   (clk),
			.we    (adv && v_s1 && (cmd_s1 == CMD_WRITE)),
			.waddr (widx_s1),
			.wdata (pt_s1),
			.re    (adv),
			.raddr (raddr[k]),
			.rdata (rdata[k])
		);
	end

	// s2: local time travels with the table read
	always_ff @(posedge clk) begin
		if (adv) begin
			l_s2 <= s_s1[FRAC_BITS-1:0];
		end
	end

	// Coordinate lanes, s3 to s9
	crs_coord #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_x (
		.clk(clk), .adv(adv),
		.p0(rdata[0][0 +: COORD_BITS]), .p1(rdata[1][0 +: COORD_BITS]),
		.p2(rdata[2][0 +: COORD_BITS]), .p3(rdata[3][0 +: COORD_BITS]),
		.lt(l_s2), .value(ox), .sat(sx)
	);

	crs_coord #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_y (
		.clk(clk), .adv(adv),
		.p0(rdata[0][COORD_BITS +: COORD_BITS]), .p1(rdata[1][COORD_BITS +: COORD_BITS]),
		.p2(rdata[2][COORD_BITS +: COORD_BITS]), .p3(rdata[3][COORD_BITS +: COORD_BITS]),
		.lt(l_s2), .value(oy), .sat(sy)
	);

	crs_coord #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_z (
		.clk(clk), .adv(adv),
		.p0(rdata[0][2*COORD_BITS +: COORD_BITS]), .p1(rdata[1][2*COORD_BITS +: COORD_BITS]),
		.p2(rdata[2][2*COORD_BITS +: COORD_BITS]), .p3(rdata[3][2*COORD_BITS +: COORD_BITS]),
		.lt(l_s2), .value(oz), .sat(sz)
	);

	// Output stream
	assign m_tvalid = v_s9;
	assign m_tuser  = sx || sy || sz;

	always_comb begin
		m_tdata = '0;
		m_tdata[PTW-1:0] = {oz, oy, ox};
	end

	// Checks
	`CRS_ASSERT_NEXT(a_write_no_result, clk, arst_n,
		adv && v_s1 && (cmd_s1 == CMD_WRITE), !v_s2)
	`CRS_ASSERT_NOW(a_read_in_range, clk, arst_n,
		v_s1 && (cmd_s1 != CMD_WRITE),
		(CNT_W+1)'(raddr[0]) < (CNT_W+1)'(cnt_q) && (CNT_W+1)'(raddr[3]) < (CNT_W+1)'(cnt_q))
	`CRS_ASSERT_NEXT(a_freeze, clk, arst_n,
		!adv, $stable(v_s2) && $stable(v_s5) && $stable(v_s8) && v_s9)
	`CRS_ASSERT_NOW(a_sat_extreme, clk, arst_n,
		m_tvalid && m_tuser,
		ox[COORD_BITS-2:0] == '1 || ox[COORD_BITS-2:0] == '0 ||
		oy[COORD_BITS-2:0] == '1 || oy[COORD_BITS-2:0] == '0 ||
		oz[COORD_BITS-2:0] == '1 || oz[COORD_BITS-2:0] == '0)

endmodule
